@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/lir_pkg.sv @@
// ----------------------------------------------------------------------------
// lir_pkg
// shared types and constants of the linear interpolation resampler
// ----------------------------------------------------------------------------
package lir_pkg;

   localparam int RATE_W         = 19;
   localparam int PHASE_W        = 40;
   localparam int MAX_RUN        = 64;
   localparam int RUN_W          = 7;
   localparam int STEP_MIN_SHIFT = 6;
   localparam int CSR_IDX_W      = 2;

   localparam logic [RATE_W-1:0]    DEFAULT_RATE    = RATE_W'(48000);
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_RATE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_RATE = CSR_IDX_W'(1);

   typedef struct packed {
      logic              start;
      logic [RATE_W-1:0] src;
      logic [RATE_W-1:0] tgt;
   } lir_div_req_type;

   typedef struct packed {
      logic busy;
   } lir_div_status_type;

   typedef struct packed {
      logic done;
      logic sticky;
   } lir_mul_status_type;

endpackage

@@ design/lir_req_if.sv @@
// ----------------------------------------------------------------------------
// lir_req_if
// input sample channel: request code and signed sample
// ----------------------------------------------------------------------------
interface lir_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output func, output sample, input ready);
   modport sink   (input valid, input func, input sample, output ready);
endinterface

@@ design/lir_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lir_rsp_if
// output sample channel: interpolated sample and end-of-run flag
// ----------------------------------------------------------------------------
interface lir_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_sample;
   logic                          last;

   modport source (output valid, output out_sample, output last, input ready);
   modport sink   (input valid, input out_sample, input last, output ready);
endinterface

@@ design/lir_csr_if.sv @@
// ----------------------------------------------------------------------------
// lir_csr_if
// register write channel: register index and write data
// ----------------------------------------------------------------------------
interface lir_csr_if;
   logic                          valid;
   logic                          ready;
   logic [lir_pkg::CSR_IDX_W-1:0] index;
   logic [lir_pkg::RATE_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/lir_step_div.sv @@
// ----------------------------------------------------------------------------
// lir_step_div
// bit-serial restoring divider for the phase step, one quotient bit a cycle
// ----------------------------------------------------------------------------
module lir_step_div #(
   parameter int FRAC_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lir_pkg::lir_div_req_type            req,
   output logic [lir_pkg::PHASE_W-1:0]         step,
   output lir_pkg::lir_div_status_type         status
);
   import lir_pkg::*;

   localparam int DIV_W = RATE_W + FRAC_BITS;
   localparam int CMP_W = (DIV_W > PHASE_W) ? DIV_W : PHASE_W;
   localparam int CNT_W = $clog2(DIV_W + 1);
   localparam logic [CMP_W-1:0] STEP_LO = CMP_W'(1) << (FRAC_BITS - STEP_MIN_SHIFT);
   localparam logic [CMP_W-1:0] STEP_HI = CMP_W'(1) << (PHASE_W - 1);

   logic               busy_ff, busy_in;
   logic               fin_ff, fin_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_W-1:0]   dvd_ff, dvd_in;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [RATE_W-1:0]  rem_ff, rem_in;
   logic [RATE_W-1:0]  tgt_ff, tgt_in;
   logic [PHASE_W-1:0] step_ff, step_in;

   logic [RATE_W:0]    trial;
   logic [RATE_W:0]    diff;
   logic               qbit;
   logic [CMP_W-1:0]   quo_ext;

   always_comb begin
      trial   = {rem_ff, dvd_ff[DIV_W-1]};
      diff    = trial - {1'b0, tgt_ff};
      qbit    = (trial >= {1'b0, tgt_ff});
      quo_ext = CMP_W'(quo_ff);

      busy_in = busy_ff;
      fin_in  = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      tgt_in  = tgt_ff;
      step_in = step_ff;

      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W);
         dvd_in  = {req.src, {FRAC_BITS{1'b0}}};
         quo_in  = '0;
         rem_in  = '0;
         tgt_in  = req.tgt;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], qbit};
         dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end

      // clamp so a run stays within the result limit and the phase width
      if (fin_ff) begin
         if (quo_ext < STEP_LO) begin
            step_in = PHASE_W'(STEP_LO);
         end else if (quo_ext > STEP_HI) begin
            step_in = PHASE_W'(STEP_HI);
         end else begin
            step_in = PHASE_W'(quo_ext);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         cnt_ff  <= '0;
         step_ff <= PHASE_W'(1) << FRAC_BITS;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         cnt_ff  <= cnt_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      tgt_ff <= tgt_in;
   end

   assign step        = step_ff;
   assign status.busy = busy_ff | fin_ff;

endmodule

@@ design/lir_ser_mul.sv @@
// ----------------------------------------------------------------------------
// lir_ser_mul
// shift-add multiplier, one fraction bit a cycle; keeps the high product
// and a sticky flag for the discarded low bits
// ----------------------------------------------------------------------------
module lir_ser_mul #(
   parameter int MAG_W     = 17,
   parameter int FRAC_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [MAG_W-1:0]            mag,
   input  logic [FRAC_BITS-1:0]        frac,
   output logic [MAG_W-1:0]            quo,
   output lir_pkg::lir_mul_status_type status
);
   import lir_pkg::*;

   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [MAG_W-1:0]     mcand_ff, mcand_in;
   logic [FRAC_BITS-1:0] mplr_ff, mplr_in;
   logic [MAG_W-1:0]     acc_ff, acc_in;
   logic                 sticky_ff, sticky_in;
   logic [MAG_W:0]       sum;

   always_comb begin
      sum = {1'b0, acc_ff} + (mplr_ff[0] ? {1'b0, mcand_ff} : {(MAG_W + 1){1'b0}});

      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplr_in   = mplr_ff;
      acc_in    = acc_ff;
      sticky_in = sticky_ff;

      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = CNT_W'(FRAC_BITS);
         mcand_in  = mag;
         mplr_in   = frac;
         acc_in    = '0;
         sticky_in = 1'b0;
      end else if (busy_ff) begin
         acc_in    = sum[MAG_W:1];
         sticky_in = sticky_ff | sum[0];
         mplr_in   = {1'b0, mplr_ff[FRAC_BITS-1:1]};
         cnt_in    = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff  <= mcand_in;
      mplr_ff   <= mplr_in;
      acc_ff    <= acc_in;
      sticky_ff <= sticky_in;
   end

   assign quo           = acc_ff;
   assign status.done   = done_ff;
   assign status.sticky = sticky_ff;

endmodule

@@ design/linear_interp_resampler.sv @@
// ----------------------------------------------------------------------------
// linear_interp_resampler
// streaming audio rate converter by linear interpolation on a Q phase
// ----------------------------------------------------------------------------
// req_if takes one sample beat (func 0) or a clear beat (func 1, resets the
// phase and the previous sample, no output). rsp_if gives zero to 64 output
// beats per sample; last marks the final beat of a sample's run. csr_if
// writes source_rate (index 0) or target_rate (index 1); zero means 48000.
// Equal rates pass samples straight through, one beat each.
// After a rate write the bit-serial step divider runs; req_if and csr_if stall
// until it finishes. An input beat is taken only once the previous run has
// ended. Each output beat is computed by the bit-serial interpolation
// multiplier; a clear beat and a pass-through beat do not use it.
// Reset clears phase and previous sample, sets both rates to 48000 and the
// step to one. A single output register holds the current beat; when rsp_if
// stalls, the run waits at that register and nothing is dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module linear_interp_resampler #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS   = 32
) (
   input  logic            clock,
   input  logic            reset,
   lir_req_if.sink         req_if,
   lir_rsp_if.source       rsp_if,
   lir_csr_if.sink         csr_if
);
   import lir_pkg::*;

   localparam int MAG_W = SAMPLE_BITS + 1;
   localparam logic [PHASE_W-1:0] ONE_Q   = PHASE_W'(1) << FRAC_BITS;
   localparam logic [RUN_W-1:0]   RUN_CAP  = RUN_W'(MAX_RUN);
   localparam logic [RUN_W-1:0]   RUN_LAST = RUN_W'(MAX_RUN - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_MUL,
      ST_PUSH,
      ST_END,
      ST_BYPASS
   } state_type;

   state_type                   state_ff, state_in;
   logic [RATE_W-1:0]           src_ff, src_in;
   logic [RATE_W-1:0]           tgt_ff, tgt_in;
   logic                        bypass_ff, bypass_in;
   logic [PHASE_W-1:0]          phase_ff, phase_in;
   logic signed [SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic [RUN_W-1:0]            run_cnt_ff, run_cnt_in;
   logic                        out_valid_ff, out_valid_in;
   logic signed [SAMPLE_BITS-1:0] out_sample_ff, out_sample_in;
   logic                        out_last_ff, out_last_in;

   lir_div_req_type             div_req;
   lir_div_status_type          div_st;
   logic [PHASE_W-1:0]          step;
   lir_mul_status_type          mul_st;
   logic [MAG_W-1:0]            mul_quo;
   logic                        mul_start;

   logic                        csr_fire, csr_hit, req_fire, slot_free, push_load;
   logic [RATE_W-1:0]           src_eff, tgt_eff;
   logic signed [MAG_W-1:0]     prev_ext, diff;
   logic                        diff_neg;
   logic [MAG_W-1:0]            mag;
   logic [MAG_W-1:0]            y_wide;
   logic [PHASE_W-1:0]          phase_sum;
   logic                        phase_below, sum_below, last_res;

   // register writes and step request
   always_comb begin
      csr_fire = csr_if.valid & csr_if.ready;
      csr_hit  = csr_fire &
                 ((csr_if.index == REG_SOURCE_RATE) | (csr_if.index == REG_TARGET_RATE));
      src_in   = (csr_fire && csr_if.index == REG_SOURCE_RATE) ? csr_if.data : src_ff;
      tgt_in   = (csr_fire && csr_if.index == REG_TARGET_RATE) ? csr_if.data : tgt_ff;
      src_eff  = (src_in == '0) ? DEFAULT_RATE : src_in;
      tgt_eff  = (tgt_in == '0) ? DEFAULT_RATE : tgt_in;
      bypass_in     = csr_hit ? (src_eff == tgt_eff) : bypass_ff;
      div_req.start = csr_hit;
      div_req.src   = src_eff;
      div_req.tgt   = tgt_eff;
   end

   // interpolation datapath
   always_comb begin
      prev_ext    = {prev_ff[SAMPLE_BITS-1], prev_ff};
      diff        = {x_ff[SAMPLE_BITS-1], x_ff} - prev_ext;
      diff_neg    = diff[MAG_W-1];
      mag         = diff_neg ? MAG_W'(-diff) : MAG_W'(diff);
      y_wide      = diff_neg ? (prev_ext - mul_quo - MAG_W'(mul_st.sticky))
                             : (prev_ext + mul_quo);
      phase_sum   = phase_ff + step;
      phase_below = (phase_ff[PHASE_W-1:FRAC_BITS] == '0);
      sum_below   = (phase_sum[PHASE_W-1:FRAC_BITS] == '0);
      last_res    = !sum_below || (run_cnt_ff == RUN_LAST);
   end

   // run sequencer
   always_comb begin
      req_fire  = req_if.valid & req_if.ready;
      slot_free = !out_valid_ff | rsp_if.ready;
      push_load = 1'b0;
      mul_start = 1'b0;

      state_in      = state_ff;
      phase_in      = phase_ff;
      prev_in       = prev_ff;
      x_in          = x_ff;
      run_cnt_in    = run_cnt_ff;
      out_valid_in  = out_valid_ff & !rsp_if.ready;
      out_sample_in = out_sample_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               x_in       = req_if.sample;
               run_cnt_in = '0;
               if (req_if.func) begin
                  phase_in = '0;
                  prev_in  = '0;
               end else if (bypass_ff) begin
                  state_in = ST_BYPASS;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (phase_below) begin
               mul_start = 1'b1;
               state_in  = ST_MUL;
            end else begin
               state_in = ST_END;
            end
         end
         ST_MUL: begin
            if (mul_st.done) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (slot_free) begin
               push_load     = 1'b1;
               out_valid_in  = 1'b1;
               out_sample_in = y_wide[SAMPLE_BITS-1:0];
               out_last_in   = last_res;
               phase_in      = phase_sum;
               run_cnt_in    = run_cnt_ff + RUN_W'(1);
               state_in      = last_res ? ST_END : ST_RUN;
            end
         end
         ST_END: begin
            phase_in = phase_below ? '0 : (phase_ff - ONE_Q);
            prev_in  = x_ff;
            state_in = ST_IDLE;
         end
         ST_BYPASS: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_sample_in = x_ff;
               out_last_in   = 1'b1;
               prev_in       = x_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         src_ff       <= DEFAULT_RATE;
         tgt_ff       <= DEFAULT_RATE;
         bypass_ff    <= 1'b1;
         phase_ff     <= '0;
         prev_ff      <= '0;
         run_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_ff       <= src_in;
         tgt_ff       <= tgt_in;
         bypass_ff    <= bypass_in;
         phase_ff     <= phase_in;
         prev_ff      <= prev_in;
         run_cnt_ff   <= run_cnt_in;
         out_valid_ff <= out_valid_in;
      end
      x_ff          <= x_in;
      out_sample_ff <= out_sample_in;
      out_last_ff   <= out_last_in;
   end

   lir_step_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_step_div (
      .clock  (clock),
      .reset  (reset),
      .req    (div_req),
      .step   (step),
      .status (div_st)
   );

   lir_ser_mul #(
      .MAG_W     (MAG_W),
      .FRAC_BITS (FRAC_BITS)
   ) u_ser_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .mag    (mag),
      .frac   (phase_ff[FRAC_BITS-1:0]),
      .quo    (mul_quo),
      .status (mul_st)
   );

   assign req_if.ready      = (state_ff == ST_IDLE) & !div_st.busy;
   assign csr_if.ready      = !div_st.busy;
   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.out_sample = out_sample_ff;
   assign rsp_if.last       = out_last_ff;

   `ASSERT_IMPLIES(a_no_req_during_div, req_fire, !div_st.busy, "sample taken while dividing")
   `ASSERT_ALWAYS(a_run_bound, run_cnt_ff <= RUN_CAP, "run count past limit")
   `ASSERT_IMPLIES(a_push_below_one, state_ff == ST_PUSH, phase_below, "push with phase past one")
   `ASSERT_NEXT(a_run_continues, push_load && !last_res, state_ff == ST_RUN, "run ended early")
   `ASSERT_IMPLIES(a_mul_done_in_mul, mul_st.done, state_ff == ST_MUL, "multiply done off state")

endmodule

@@ tb/linear_interp_resampler_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interp_resampler_tb
// streams samples and clears through the resampler over a series of rate
// settings, predicts every output beat from its own phase and step tracking,
// and checks each beat in order under random input gaps and output stalls
// ----------------------------------------------------------------------------
module linear_interp_resampler_tb;
   import lir_pkg::*;

   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 32;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_CLEAR  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_3 = CSR_IDX_W'(3);

   localparam logic [PHASE_W-1:0] ONE_Q    = PHASE_W'(1) << FRAC_BITS;
   localparam logic [PHASE_W-1:0] STEP_MIN = ONE_Q >> STEP_MIN_SHIFT;
   localparam logic [PHASE_W-1:0] STEP_MAX = PHASE_W'(1) << (PHASE_W - 1);

   localparam logic [RATE_W-1:0]      RATE_ALL_ONES = '1;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX    = 16'h7fff;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN    = 16'h8000;

   localparam int BEAT_CYCLES   = FRAC_BITS + 3;
   localparam int SETTLE_CYCLES = 2 * BEAT_CYCLES + 16;
   localparam int END_CYCLES    = 4 * BEAT_CYCLES;
   localparam int CYCLE_LIMIT   = 4000000;
   localparam int RANDOM_PHASES = 7;

   typedef struct {
      logic                          func;
      logic signed [SAMPLE_BITS-1:0] sample;
      bit                            drain_first;
   } sample_item_type;

   typedef struct {
      logic [SAMPLE_BITS-1:0] out_sample;
      logic                   last;
   } out_beat_type;

   typedef enum logic [1:0] {PACE_FREE, PACE_COIN, PACE_SPARSE, PACE_THIN} rsp_pace_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid  = 1'b0;
   logic                          req_func   = FUNC_SAMPLE;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic                          rsp_ready  = 1'b0;
   logic                          csr_valid  = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index  = REG_SOURCE_RATE;
   logic [RATE_W-1:0]             csr_data   = '0;

   lir_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_if ();
   lir_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_if ();
   lir_csr_if                              csr_if ();

   assign req_if.valid  = req_valid;
   assign req_if.func   = req_func;
   assign req_if.sample = req_sample;
   assign rsp_if.ready  = rsp_ready;
   assign csr_if.valid  = csr_valid;
   assign csr_if.index  = csr_index;
   assign csr_if.data   = csr_data;

   linear_interp_resampler #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   always #4 clock = ~clock;

   // predicted resampler state
   logic [RATE_W-1:0]             pred_src  = DEFAULT_RATE;
   logic [RATE_W-1:0]             pred_tgt  = DEFAULT_RATE;
   logic [PHASE_W-1:0]            phase_acc = '0;
   logic signed [SAMPLE_BITS-1:0] pred_prev = '0;
   logic [PHASE_W-1:0]            phase_step = ONE_Q;

   sample_item_type pending_samples[$];
   out_beat_type    expected_beats[$];
   out_beat_type    head_beat;
   sample_item_type next_item;

   int unsigned cycle_count = 0;
   int          gap_left = 0;
   int          burst_left = 0;
   int          mismatches = 0;
   int          beats_checked = 0;
   int          runs_closed = 0;
   int          samples_taken = 0;
   int          clears_taken = 0;
   int          bypass_beats = 0;
   int          empty_runs = 0;
   int          reg_writes = 0;
   int          drain_pauses = 0;

   function automatic longint unsigned eff_rate(input logic [RATE_W-1:0] r);
      return (r == '0) ? longint'(DEFAULT_RATE) : longint'(r);
   endfunction

   function automatic logic [PHASE_W-1:0] step_for_rates(input logic [RATE_W-1:0] s,
                                                          input logic [RATE_W-1:0] t);
      longint unsigned q;
      q = (eff_rate(s) << FRAC_BITS) / eff_rate(t);
      if (q < STEP_MIN) q = STEP_MIN;
      if (q > STEP_MAX) q = STEP_MAX;
      return q[PHASE_W-1:0];
   endfunction

   // advances the predicted state by one beat and queues its output beats
   function automatic void predict_run(input logic func,
                                       input logic signed [SAMPLE_BITS-1:0] smp);
      longint             x;
      longint             a;
      longint             frac;
      longint             prod;
      longint             y;
      logic [PHASE_W-1:0] ph;
      int                 n;
      out_beat_type       b;
      if (func == FUNC_CLEAR) begin
         phase_acc = '0;
         pred_prev = '0;
         clears_taken++;
         return;
      end
      samples_taken++;
      if (eff_rate(pred_src) == eff_rate(pred_tgt)) begin
         b.out_sample = smp;
         b.last       = 1'b1;
         expected_beats.push_back(b);
         pred_prev    = smp;
         bypass_beats++;
         return;
      end
      x  = smp;
      ph = phase_acc;
      n  = 0;
      while (ph < ONE_Q && n < MAX_RUN) begin
         a    = pred_prev;
         frac = ph[FRAC_BITS-1:0];
         prod = (x - a) * frac;
         y    = a + (prod >>> FRAC_BITS);
         b.out_sample = y[SAMPLE_BITS-1:0];
         b.last       = 1'b0;
         expected_beats.push_back(b);
         n++;
         ph = ph + phase_step;
      end
      if (n > 0) expected_beats[expected_beats.size() - 1].last = 1'b1;
      else empty_runs++;
      if (ph >= ONE_Q) ph = ph - ONE_Q;
      else ph = '0;
      phase_acc = ph;
      pred_prev = smp;
   endfunction

   task automatic report_error(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
   endtask

   // input driver: bursts with random gaps, optional drain before an item
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_if.ready) predict_run(req_func, req_sample);
         if (!req_valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() != 0 &&
                         !(pending_samples[0].drain_first && expected_beats.size() != 0)) begin
               next_item = pending_samples.pop_front();
               if (next_item.drain_first) drain_pauses++;
               req_valid  <= 1'b1;
               req_func   <= next_item.func;
               req_sample <= next_item.sample;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 20);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // output monitor with its own stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         case (rsp_pace_type'(cycle_count[10:9]))
            PACE_FREE:   rsp_ready <= 1'b1;
            PACE_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            PACE_SPARSE: rsp_ready <= (cycle_count[3:0] < 4'd3);
            default:     rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
         if (rsp_if.valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               report_error($sformatf("beat with nothing expected: out_sample %0d, last %0d",
                                      $signed(rsp_if.out_sample), rsp_if.last));
            end else begin
               head_beat = expected_beats.pop_front();
               if (rsp_if.out_sample !== head_beat.out_sample)
                  report_error($sformatf("beat %0d out_sample: expected %0d, got %0d",
                                         beats_checked, $signed(head_beat.out_sample),
                                         $signed(rsp_if.out_sample)));
               if (rsp_if.last !== head_beat.last)
                  report_error($sformatf("beat %0d last: expected %0d, got %0d",
                                         beats_checked, head_beat.last, rsp_if.last));
            end
            beats_checked++;
            if (rsp_if.last === 1'b1) runs_closed++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still expected",
                  CYCLE_LIMIT, expected_beats.size());
         $display("Verification failed");
         $finish;
      end
   end

   function automatic void push_item(input logic func,
                                     input logic signed [SAMPLE_BITS-1:0] smp,
                                     input bit drain);
      sample_item_type it;
      it.func        = func;
      it.sample      = smp;
      it.drain_first = drain;
      pending_samples.push_back(it);
   endfunction

   function automatic int common_rate(input int i);
      case (i)
         0:       return 8000;
         1:       return 11025;
         2:       return 16000;
         3:       return 22050;
         4:       return 32000;
         5:       return 44100;
         6:       return 48000;
         7:       return 88200;
         8:       return 96000;
         9:       return 176400;
         10:      return 192000;
         default: return 384000;
      endcase
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_beats.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock);
      while (!csr_if.ready);
      csr_valid <= 1'b0;
      reg_writes++;
      if (idx == REG_SOURCE_RATE) pred_src = val;
      if (idx == REG_TARGET_RATE) pred_tgt = val;
      if (idx == REG_SOURCE_RATE || idx == REG_TARGET_RATE)
         phase_step = step_for_rates(pred_src, pred_tgt);
   endtask

   task automatic set_rates(input logic [RATE_W-1:0] s, input logic [RATE_W-1:0] t);
      wait_idle();
      write_reg(REG_SOURCE_RATE, s);
      write_reg(REG_TARGET_RATE, t);
   endtask

   task automatic pick_rates(input int kind, output logic [RATE_W-1:0] s,
                             output logic [RATE_W-1:0] t);
      int r;
      case (kind)
         1: begin
            r = $urandom_range(1, 524287);
            s = RATE_W'(r);
            t = RATE_W'(r);
         end
         2: begin
            s = RATE_W'($urandom_range(0, 524287));
            t = RATE_W'($urandom_range(0, 524287));
         end
         3: begin
            s = RATE_W'($urandom_range(8000, 48000));
            t = RATE_W'(s * $urandom_range(2, 5) + $urandom_range(0, 999));
         end
         4: begin
            t = RATE_W'($urandom_range(8000, 48000));
            s = RATE_W'(t * $urandom_range(2, 8) + $urandom_range(0, 999));
         end
         5: begin
            s = '0;
            t = RATE_W'(common_rate($urandom_range(0, 11)));
         end
         default: begin
            s = RATE_W'(common_rate($urandom_range(0, 11)));
            t = RATE_W'(common_rate($urandom_range(0, 11)));
         end
      endcase
   endtask

   task automatic queue_random_phase(input int count, input bit force_drain);
      int                            level;
      int                            i;
      bit                            walk;
      logic signed [SAMPLE_BITS-1:0] smp;
      level = 0;
      walk  = 1'($urandom_range(0, 1));
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 11) == 0) begin
            case ($urandom_range(0, 3))
               0:       smp = SAMPLE_MAX;
               1:       smp = SAMPLE_MIN;
               2:       smp = '0;
               default: smp = '1;
            endcase
         end else if (walk) begin
            level = level + $urandom_range(0, 6000) - 3000;
            if (level > 32767) level = 32767;
            if (level < -32768) level = -32768;
            smp = level[SAMPLE_BITS-1:0];
         end else begin
            smp = SAMPLE_BITS'($urandom_range(0, 65535));
         end
         push_item(($urandom_range(0, 15) == 0) ? FUNC_CLEAR : FUNC_SAMPLE, smp,
                   (force_drain && i == count / 2) || $urandom_range(0, 39) == 0);
      end
   endtask

   initial begin
      int                k;
      logic [RATE_W-1:0] s;
      logic [RATE_W-1:0] t;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // pass-through at the reset rates, extremes and a clear
      push_item(FUNC_SAMPLE, SAMPLE_MAX, 1'b0);
      push_item(FUNC_SAMPLE, SAMPLE_MIN, 1'b0);
      push_item(FUNC_SAMPLE, '0, 1'b0);
      push_item(FUNC_SAMPLE, '1, 1'b0);
      push_item(FUNC_CLEAR, 16'h5a5a, 1'b0);

      // mild upsampling; unused register indexes must not disturb the step
      set_rates(RATE_W'(44100), RATE_W'(48000));
      write_reg(REG_SPARE_2, RATE_W'($urandom_range(0, 524287)));
      write_reg(REG_SPARE_3, RATE_ALL_ONES);
      push_item(FUNC_SAMPLE, SAMPLE_MIN, 1'b0);
      push_item(FUNC_SAMPLE, SAMPLE_MAX, 1'b0);
      push_item(FUNC_SAMPLE, '0, 1'b0);
      push_item(FUNC_CLEAR, '1, 1'b0);
      push_item(FUNC_SAMPLE, 16'sd12345, 1'b0);

      // step held at its floor: full 64-beat runs
      set_rates(RATE_W'(1), RATE_ALL_ONES);
      push_item(FUNC_SAMPLE, SAMPLE_MAX, 1'b0);
      push_item(FUNC_SAMPLE, SAMPLE_MIN, 1'b0);
      push_item(FUNC_CLEAR, '0, 1'b0);
      push_item(FUNC_SAMPLE, 16'sd100, 1'b0);

      // step held at its ceiling: excess phase swallows inputs until a clear
      set_rates(RATE_ALL_ONES, RATE_W'(1));
      push_item(FUNC_SAMPLE, SAMPLE_MIN, 1'b0);
      push_item(FUNC_SAMPLE, SAMPLE_MAX, 1'b0);
      push_item(FUNC_SAMPLE, 16'sd7, 1'b0);
      push_item(FUNC_SAMPLE, -16'sd7, 1'b0);
      push_item(FUNC_CLEAR, SAMPLE_MAX, 1'b0);
      push_item(FUNC_SAMPLE, 16'sd1000, 1'b0);

      // both rates zero select the default: pass-through
      set_rates('0, '0);
      push_item(FUNC_SAMPLE, 16'sd1234, 1'b0);

      // top rate against a defaulted target
      set_rates(RATE_W'(384000), '0);
      push_item(FUNC_SAMPLE, -16'sd20000, 1'b0);
      push_item(FUNC_SAMPLE, 16'sd20000, 1'b0);
      push_item(FUNC_SAMPLE, SAMPLE_MAX, 1'b0);

      for (k = 0; k < RANDOM_PHASES; k++) begin
         pick_rates(k, s, t);
         set_rates(s, t);
         queue_random_phase((eff_rate(t) > 8 * eff_rate(s)) ? 8 : 27, k == 3);
      end

      wait_idle();
      repeat (END_CYCLES) @(posedge clock);
      $display("ran %0d samples and %0d clears over %0d register writes, %0d drain pauses",
               samples_taken, clears_taken, reg_writes, drain_pauses);
      $display("checked %0d output beats in %0d runs (%0d pass-through, %0d empty runs)",
               beats_checked, runs_closed, bypass_beats, empty_runs);
      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d beats missing", mismatches, expected_beats.size());
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+design
design/lir_pkg.sv
design/lir_req_if.sv
design/lir_rsp_if.sv
design/lir_csr_if.sv
design/lir_step_div.sv
design/lir_ser_mul.sv
design/linear_interp_resampler.sv
tb/linear_interp_resampler_tb.sv
